### sv/aclf_pkg.sv
// ----------------------------------------------------------------------------
// aclf_pkg
// shared types and constants of the first-match access rule filter
// ----------------------------------------------------------------------------
package aclf_pkg;

   // protocol codes
   localparam logic [1:0] PROTO_ANY  = 2'd0;
   localparam logic [1:0] PROTO_TCP  = 2'd1;
   localparam logic [1:0] PROTO_UDP  = 2'd2;
   localparam logic [1:0] PROTO_ICMP = 2'd3;

   // rule direction codes
   localparam logic [1:0] DIR_BOTH     = 2'd0;
   localparam logic [1:0] DIR_INBOUND  = 2'd1;
   localparam logic [1:0] DIR_OUTBOUND = 2'd2;

   // port compare codes
   localparam logic [1:0] PORT_EQ = 2'd0;
   localparam logic [1:0] PORT_GT = 2'd1;
   localparam logic [1:0] PORT_LT = 2'd2;
   localparam logic [1:0] PORT_NE = 2'd3;

   // operation codes
   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_WRITE    = 1'b1;

   // decision causes
   localparam logic [2:0] CAUSE_PERMIT    = 3'd0;
   localparam logic [2:0] CAUSE_DENY      = 3'd1;
   localparam logic [2:0] CAUSE_NOMATCH   = 3'd2;
   localparam logic [2:0] CAUSE_UNHANDLED = 3'd3;
   localparam logic [2:0] CAUSE_WRITTEN   = 3'd4;

   localparam logic [7:0] FLAG_ACK = 8'h10;
   localparam logic [7:0] FLAG_RST = 8'h04;

   localparam int ADDR_RULE_W = 64;
   localparam int ATTR_W      = 32;

   typedef struct packed {
      logic        established;
      logic        deny;
      logic [7:0]  tcp_flags;
      logic [1:0]  port_op;
      logic [15:0] port_value;
      logic [1:0]  direction;
      logic [1:0]  protocol;
   } attr_type;

   typedef struct packed {
      logic [1:0]  protocol;
      logic        inbound;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] port_value;
      logic [7:0]  tcp_flags;
      logic        conn_known;
   } packet_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

### sv/aclf_ram.sv
// ----------------------------------------------------------------------------
// aclf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module aclf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/aclf_rule_match.sv
// ----------------------------------------------------------------------------
// aclf_rule_match
// compares one stored rule against the held packet header fields
// ----------------------------------------------------------------------------
module aclf_rule_match (
   input  aclf_pkg::packet_type pkt,
   input  logic [63:0]          src_rule,
   input  logic [63:0]          dst_rule,
   input  aclf_pkg::attr_type   attr,
   output logic                 hit
);

   logic proto_ok;
   logic dir_ok;
   logic src_ok;
   logic dst_ok;
   logic port_ok;
   logic tcp_ok;
   logic l4_ok;

   always_comb begin
      proto_ok = (attr.protocol == aclf_pkg::PROTO_ANY) || (attr.protocol == pkt.protocol);
      dir_ok = (attr.direction == aclf_pkg::DIR_BOTH) ||
               (pkt.inbound && (attr.direction == aclf_pkg::DIR_INBOUND)) ||
               (!pkt.inbound && (attr.direction == aclf_pkg::DIR_OUTBOUND));
      src_ok = ((pkt.src_addr & src_rule[31:0]) == (src_rule[63:32] & src_rule[31:0]));
      dst_ok = ((pkt.dst_addr & dst_rule[31:0]) == (dst_rule[63:32] & dst_rule[31:0]));

      case (attr.port_op)
         aclf_pkg::PORT_EQ: port_ok = (pkt.port_value == attr.port_value);
         aclf_pkg::PORT_GT: port_ok = (pkt.port_value > attr.port_value);
         aclf_pkg::PORT_LT: port_ok = (pkt.port_value < attr.port_value);
         default:           port_ok = (pkt.port_value != attr.port_value);
      endcase
      if (attr.port_value == 16'd0) begin
         port_ok = 1'b1;
      end

      tcp_ok = 1'b1;
      if (attr.established && ((pkt.tcp_flags & (aclf_pkg::FLAG_ACK | aclf_pkg::FLAG_RST))
                               != 8'd0) && !pkt.conn_known) begin
         tcp_ok = 1'b0;
      end
      if ((attr.tcp_flags != 8'd0) && (attr.tcp_flags != pkt.tcp_flags)) begin
         tcp_ok = 1'b0;
      end

      case (pkt.protocol)
         aclf_pkg::PROTO_ICMP: begin
            l4_ok = (attr.port_value == 16'd0) || (attr.port_value == pkt.port_value);
         end
         aclf_pkg::PROTO_TCP: begin
            l4_ok = port_ok && tcp_ok;
         end
         default: begin
            l4_ok = port_ok;
         end
      endcase

      hit = proto_ok && dir_ok && src_ok && dst_ok && l4_ok;
   end

endmodule

### sv/acl_first_match_packet_filter.sv
// ----------------------------------------------------------------------------
// acl_first_match_packet_filter
// first-match access rule table: stores rules and classifies packet headers
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | contents
//  req     | in        | valid / stall    | rule write or packet header
//  rsp     | out       | valid / stall    | verdict, matched rule, cause
//  csr     | in        | write enable     | rule_count
//
//  a write, an unhandled protocol or an empty scan goes from the transfer
//  through ST_DONE to the rsp register; no new item is taken before it leaves ST_DONE
//  a classify scans up to min(rule_count, RULES) rules through the single read
//  port of each rule ram, one rule compared per cycle, stopping at a hit
//  reset clears rule_count and the control state; the rule table is not cleared
//  req_stall is high while an item is in work; a result held by rsp_stall
//  keeps the next item from finishing but not from being taken
// ----------------------------------------------------------------------------
module acl_first_match_packet_filter #(
   parameter int RULES = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [5:0]  req_entry_index,
   input  logic [1:0]  req_protocol,
   input  logic [1:0]  req_direction,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_src_mask,
   input  logic [31:0] req_dst_addr,
   input  logic [31:0] req_dst_mask,
   input  logic [15:0] req_port_value,
   input  logic [1:0]  req_port_op,
   input  logic [7:0]  req_tcp_flags,
   input  logic [1:0]  req_flag_bits,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_allow,
   output logic        rsp_matched,
   output logic [5:0]  rsp_matched_rule,
   output logic [2:0]  rsp_decision_cause,

   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int CNT_W = $clog2(RULES + 1);

   aclf_pkg::state_type  state_ff, state_in;
   logic [6:0]           rule_count_ff;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   aclf_pkg::packet_type pkt_ff, pkt_in;
   logic                 res_allow_ff, res_allow_in;
   logic                 res_matched_ff, res_matched_in;
   logic [5:0]           res_rule_ff, res_rule_in;
   logic [2:0]           res_cause_ff, res_cause_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_allow_ff, rsp_allow_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic [5:0]           rsp_rule_ff, rsp_rule_in;
   logic [2:0]           rsp_cause_ff, rsp_cause_in;

   logic                  req_xfer;
   logic                  wr_en;
   logic [IDX_W+5:0]      entry_wide;
   logic [CNT_W+6:0]      count_wide;
   logic [CNT_W-1:0]      limit_calc;
   logic                  rd_issue;
   logic [63:0]           src_rule;
   logic [63:0]           dst_rule;
   aclf_pkg::attr_type    attr_word;
   aclf_pkg::attr_type    wr_attr;
   logic                  hit;
   logic                  out_free;
   logic [IDX_W+5:0]      eval_idx_wide;

   assign req_stall = (state_ff != aclf_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign entry_wide = {{IDX_W{1'b0}}, req_entry_index};
   assign wr_en = req_xfer && (req_operation == aclf_pkg::OP_WRITE) &&
                  (entry_wide < RULES);

   assign count_wide = {{CNT_W{1'b0}}, rule_count_ff};
   assign limit_calc = (count_wide > RULES) ? CNT_W'(RULES) : count_wide[CNT_W-1:0];

   assign rd_issue = (state_ff == aclf_pkg::ST_SCAN) && (rd_ptr_ff < limit_ff);

   assign wr_attr = '{established: req_flag_bits[1], deny: req_flag_bits[0],
                      tcp_flags: req_tcp_flags, port_op: req_port_op,
                      port_value: req_port_value, direction: req_direction,
                      protocol: req_protocol};

   aclf_ram #(.WIDTH(aclf_pkg::ADDR_RULE_W), .DEPTH(RULES), .ADDR_W(IDX_W)) u_src_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_wide[IDX_W-1:0]),
      .wr_data ({req_src_addr, req_src_mask}),
      .rd_en   (rd_issue),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (src_rule)
   );

   aclf_ram #(.WIDTH(aclf_pkg::ADDR_RULE_W), .DEPTH(RULES), .ADDR_W(IDX_W)) u_dst_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_wide[IDX_W-1:0]),
      .wr_data ({req_dst_addr, req_dst_mask}),
      .rd_en   (rd_issue),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (dst_rule)
   );

   aclf_ram #(.WIDTH(aclf_pkg::ATTR_W), .DEPTH(RULES), .ADDR_W(IDX_W)) u_attr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_wide[IDX_W-1:0]),
      .wr_data (wr_attr),
      .rd_en   (rd_issue),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (attr_word)
   );

   aclf_rule_match u_match (
      .pkt      (pkt_ff),
      .src_rule (src_rule),
      .dst_rule (dst_rule),
      .attr     (attr_word),
      .hit      (hit)
   );

   assign eval_idx_wide = {6'd0, eval_idx_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      limit_in       = limit_ff;
      rd_ptr_in      = rd_ptr_ff;
      eval_vld_in    = 1'b0;
      eval_idx_in    = eval_idx_ff;
      pkt_in         = pkt_ff;
      res_allow_in   = res_allow_ff;
      res_matched_in = res_matched_ff;
      res_rule_in    = res_rule_ff;
      res_cause_in   = res_cause_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_allow_in   = rsp_allow_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_rule_in    = rsp_rule_ff;
      rsp_cause_in   = rsp_cause_ff;

      case (state_ff)
         aclf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               pkt_in = '{protocol: req_protocol, inbound: req_direction[0],
                          src_addr: req_src_addr, dst_addr: req_dst_addr,
                          port_value: req_port_value, tcp_flags: req_tcp_flags,
                          conn_known: req_flag_bits[0]};
               limit_in       = limit_calc;
               rd_ptr_in      = '0;
               res_allow_in   = 1'b0;
               res_matched_in = 1'b0;
               res_rule_in    = 6'd0;
               state_in       = aclf_pkg::ST_DONE;
               if (req_operation == aclf_pkg::OP_WRITE) begin
                  res_cause_in = aclf_pkg::CAUSE_WRITTEN;
               end else if (req_protocol == aclf_pkg::PROTO_ANY) begin
                  res_cause_in = aclf_pkg::CAUSE_UNHANDLED;
               end else if (limit_calc == '0) begin
                  res_cause_in = aclf_pkg::CAUSE_NOMATCH;
               end else begin
                  res_cause_in = aclf_pkg::CAUSE_NOMATCH;
                  state_in     = aclf_pkg::ST_SCAN;
               end
            end
         end
         aclf_pkg::ST_SCAN: begin
            if (rd_issue) begin
               eval_vld_in = 1'b1;
               eval_idx_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            end
            if (eval_vld_ff && hit) begin
               eval_vld_in    = 1'b0;
               res_matched_in = 1'b1;
               res_rule_in    = eval_idx_wide[5:0];
               if (attr_word.deny) begin
                  res_allow_in = 1'b0;
                  res_cause_in = aclf_pkg::CAUSE_DENY;
               end else begin
                  res_allow_in = 1'b1;
                  res_cause_in = aclf_pkg::CAUSE_PERMIT;
               end
               state_in = aclf_pkg::ST_DONE;
            end else if (eval_vld_ff && !rd_issue) begin
               res_cause_in = aclf_pkg::CAUSE_NOMATCH;
               state_in     = aclf_pkg::ST_DONE;
            end
         end
         aclf_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_allow_in   = res_allow_ff;
               rsp_matched_in = res_matched_ff;
               rsp_rule_in    = res_rule_ff;
               rsp_cause_in   = res_cause_ff;
               state_in       = aclf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aclf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= aclf_pkg::ST_IDLE;
         rule_count_ff <= 7'd0;
         eval_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rule_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff       <= limit_in;
      rd_ptr_ff      <= rd_ptr_in;
      eval_idx_ff    <= eval_idx_in;
      pkt_ff         <= pkt_in;
      res_allow_ff   <= res_allow_in;
      res_matched_ff <= res_matched_in;
      res_rule_ff    <= res_rule_in;
      res_cause_ff   <= res_cause_in;
      rsp_allow_ff   <= rsp_allow_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_rule_ff    <= rsp_rule_in;
      rsp_cause_ff   <= rsp_cause_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_allow          = rsp_allow_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_matched_rule   = rsp_rule_ff;
   assign rsp_decision_cause = rsp_cause_ff;

   // scan never runs past the rule limit
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aclf_pkg::ST_SCAN) |-> (limit_ff != '0) && (rd_ptr_ff <= limit_ff))
      else $error("scan pointer beyond rule limit");

   // a compared rule lies inside the scanned range
   a_eval_range: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (eval_idx_wide < {6'd0, limit_ff}))
      else $error("compared rule outside scanned range");

   // a matched verdict always carries a rule cause
   a_match_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_matched_ff) |->
         ((rsp_cause_ff == aclf_pkg::CAUSE_PERMIT) || (rsp_cause_ff == aclf_pkg::CAUSE_DENY)))
      else $error("matched result without rule cause");

   // no match reports rule zero and drops
   a_nomatch_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_matched_ff) |-> (rsp_rule_ff == 6'd0) && !rsp_allow_ff)
      else $error("unmatched result with rule or allow set");

endmodule
